// ===== sv/tbbf_pkg.sv =====
// shared types, constants and helpers for the tile buffer bilinear fetch block
`default_nettype none
package tbbf_pkg;

  // tile geometry
  localparam int TILE_WORDS = 64;
  localparam int ROW_WORDS  = 4;
  localparam int NUM_TILES  = 2;
  localparam int PIX_W      = 8;
  localparam int WORD_W     = 32;
  localparam int PIX_PER_WORD = WORD_W / PIX_W;
  localparam int TILE_DIM   = ROW_WORDS * PIX_PER_WORD;
  localparam int TILE_ROWS  = TILE_WORDS / ROW_WORDS;
  localparam int ROW_W      = ROW_WORDS * WORD_W;
  localparam int COL_W      = $clog2(TILE_DIM);
  localparam int ROW_IDX_W  = $clog2(TILE_ROWS);
  localparam int LANE_W     = $clog2(ROW_WORDS);
  localparam int WWORD_W    = $clog2(TILE_WORDS);
  localparam int SLOT_W     = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
  localparam int HELD_W     = $clog2(NUM_TILES + 1);
  localparam int ADDR_W     = SLOT_W + ROW_IDX_W;
  localparam int DEPTH      = NUM_TILES * TILE_ROWS;

  // coordinate and counter widths
  localparam int COORD_W    = 8;
  localparam int OFS_W      = 16;
  localparam int P_W        = 13;
  localparam int LIMIT_W    = 13;
  localparam int COUNT_W    = 12;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(4096);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);
  localparam logic [PIX_W-1:0]   EDGE_FILL   = PIX_W'(128);

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_LOOKUPS_PER_TILE = 1'b0;

  // function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_PIXELS  = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_NO_TILE = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  // store write request: one word lane of one row
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [LANE_W-1:0] lane;
    logic [WORD_W-1:0] data;
  } wr_req_t;

  // store read request: a row and the row under it
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } rd_req_t;

  // lookup context that travels beside the store read
  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [COL_W-1:0] col;
    logic             row_last;
    logic             col_last;
    logic [PIX_W-1:0] frac_x;
    logic [PIX_W-1:0] frac_y;
    logic             tile_done;
  } meta_t;

  // ring slot advance
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    if (s == SLOT_W'(NUM_TILES - 1)) n = '0;
    else n = s + SLOT_W'(1);
    return n;
  endfunction

  // pick one pixel out of a stored row
  function automatic logic [PIX_W-1:0] row_pixel(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    return r[c*PIX_W +: PIX_W];
  endfunction

endpackage
`default_nettype wire

// ===== sv/tile_buffer_bilinear_fetch.sv =====
// top level of the tile buffer with bilinear neighbour fetch
//
// Usage: a command is transferred at a clock edge where start is high and busy
// is low; busy stays low, so one command can be issued every cycle. in_func
// selects a tile word load (in_load_word) or a lookup (in_x, in_y, in_dx, in_dy).
// Loads fill a ring of 16x16 tiles word by word; a full ring refuses the load
// and returns a result with status 3. A lookup reads the oldest complete tile
// and returns the pixel with its below, right and diagonal neighbours plus the
// fraction bytes. Every command but an accepted load gives exactly one result.
// Timing: out_valid is high for one cycle per result; the row read and decode
// are registered at the command transfer edge, and pixel select then loads
// the result register that drives out_valid and the result outputs.
// Throughput: one command per cycle, set by the two-port row
// memory that fetches a tile row and the row under it in one read.
// The receiver cannot stall; each result is taken in its strobe cycle.
// Reset (rst_n low, synchronous) empties the ring, clears the lookup count and
// sets lookups_per_tile to 1024; tile contents are not cleared and need none.
// The config register lookups_per_tile sits at byte address 0 of the APB port.
`default_nettype none
module tile_buffer_bilinear_fetch (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire                            in_func,
  input  wire  [tbbf_pkg::WORD_W-1:0]    in_load_word,
  input  wire  [tbbf_pkg::COORD_W-1:0]   in_x,
  input  wire  [tbbf_pkg::COORD_W-1:0]   in_y,
  input  wire  [tbbf_pkg::OFS_W-1:0]     in_dx,
  input  wire  [tbbf_pkg::OFS_W-1:0]     in_dy,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [tbbf_pkg::PIX_W-1:0]     out_pixel_here,
  output logic [tbbf_pkg::PIX_W-1:0]     out_pixel_below,
  output logic [tbbf_pkg::PIX_W-1:0]     out_pixel_right,
  output logic [tbbf_pkg::PIX_W-1:0]     out_pixel_diag,
  output logic [tbbf_pkg::PIX_W-1:0]     out_frac_x,
  output logic [tbbf_pkg::PIX_W-1:0]     out_frac_y,
  output logic                           out_tile_done,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [tbbf_pkg::PADDR_W-1:0]   paddr,
  input  wire  [tbbf_pkg::PDATA_W-1:0]   pwdata,
  output logic [tbbf_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import tbbf_pkg::*;

  wr_req_t          wr;
  rd_req_t          rd;
  meta_t            meta_r;
  logic [ROW_W-1:0] row_a, row_b;
  logic             accept;

  // fully pipelined, so commands are never held off
  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  tbbf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_func      (in_func),
    .in_load_word (in_load_word),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_dx        (in_dx),
    .in_dy        (in_dy),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .wr           (wr),
    .rd           (rd),
    .meta_r       (meta_r)
  );

  tbbf_store u_store (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .row_a (row_a),
    .row_b (row_b)
  );

  tbbf_select u_select (
    .clk             (clk),
    .rst_n           (rst_n),
    .meta_r          (meta_r),
    .row_a           (row_a),
    .row_b           (row_b),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_pixel_here  (out_pixel_here),
    .out_pixel_below (out_pixel_below),
    .out_pixel_right (out_pixel_right),
    .out_pixel_diag  (out_pixel_diag),
    .out_frac_x      (out_frac_x),
    .out_frac_y      (out_frac_y),
    .out_tile_done   (out_tile_done)
  );

endmodule
`default_nettype wire

// ===== sv/tbbf_store.sv =====
// tile row memory: word-lane writes, two registered row reads
`default_nettype none
module tbbf_store (
  input  wire                        clk,
  input  tbbf_pkg::wr_req_t          wr,
  input  tbbf_pkg::rd_req_t          rd,
  output logic [tbbf_pkg::ROW_W-1:0] row_a,
  output logic [tbbf_pkg::ROW_W-1:0] row_b
);
  import tbbf_pkg::*;

  logic [ROW_W-1:0] mem [DEPTH];

  // loads only touch the slot being filled, lookups only read held slots,
  // so a write and a read never hit the same row in one cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr][wr.lane*WORD_W +: WORD_W] <= wr.data;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    if (rd.en) begin
      row_a <= mem[rd.addr_a];
      row_b <= mem[rd.addr_b];
    end
  end

endmodule
`default_nettype wire

// ===== sv/tbbf_ctrl.sv =====
// ring bookkeeping, item decode, config register and store access requests
`default_nettype none
module tbbf_ctrl (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            accept,
  input  wire                            in_func,
  input  wire  [tbbf_pkg::WORD_W-1:0]    in_load_word,
  input  wire  [tbbf_pkg::COORD_W-1:0]   in_x,
  input  wire  [tbbf_pkg::COORD_W-1:0]   in_y,
  input  wire  [tbbf_pkg::OFS_W-1:0]     in_dx,
  input  wire  [tbbf_pkg::OFS_W-1:0]     in_dy,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [tbbf_pkg::PADDR_W-1:0]   paddr,
  input  wire  [tbbf_pkg::PDATA_W-1:0]   pwdata,
  output logic [tbbf_pkg::PDATA_W-1:0]   prdata,
  output tbbf_pkg::wr_req_t              wr,
  output tbbf_pkg::rd_req_t              rd,
  output tbbf_pkg::meta_t                meta_r
);
  import tbbf_pkg::*;

  logic [SLOT_W-1:0]  write_slot_r, write_slot_nxt;
  logic [WWORD_W-1:0] write_word_r, write_word_nxt;
  logic [SLOT_W-1:0]  read_slot_r, read_slot_nxt;
  logic [HELD_W-1:0]  tiles_held_r, tiles_held_nxt;
  logic [COUNT_W-1:0] lookups_done_r, lookups_done_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  meta_t              meta_nxt;

  logic               is_load, is_lookup, ring_full, ring_empty;
  logic               do_write, do_lookup, done_hit, in_tile, cfg_wr;
  logic [P_W-1:0]     p;
  logic [ROW_IDX_W-1:0] row;
  logic [COL_W-1:0]   col;
  logic [LIMIT_W-1:0] limit_eff, count_inc;

  // item decode
  always_comb begin
    is_load    = accept && (in_func == FUNC_LOAD);
    is_lookup  = accept && (in_func == FUNC_LOOKUP);
    ring_full  = (tiles_held_r == HELD_W'(NUM_TILES));
    ring_empty = (tiles_held_r == '0);
    do_write   = is_load && !ring_full;
    do_lookup  = is_lookup && !ring_empty;
    p          = P_W'(in_x) + (P_W'(in_y) << COL_W);
    in_tile    = (p >> (COL_W + ROW_IDX_W)) == '0;
    col        = p[COL_W-1:0];
    row        = p[COL_W +: ROW_IDX_W];
  end

  // lookup limit, clamped to its legal range
  always_comb begin
    if (limit_r == '0) limit_eff = LIMIT_W'(1);
    else if (limit_r > LIMIT_MAX) limit_eff = LIMIT_MAX;
    else limit_eff = limit_r;
    count_inc = LIMIT_W'(lookups_done_r) + LIMIT_W'(1);
    done_hit  = (count_inc >= limit_eff);
  end

  // ring state update
  always_comb begin
    write_slot_nxt   = write_slot_r;
    write_word_nxt   = write_word_r;
    read_slot_nxt    = read_slot_r;
    tiles_held_nxt   = tiles_held_r;
    lookups_done_nxt = lookups_done_r;
    if (do_write) begin
      if (write_word_r == WWORD_W'(TILE_WORDS - 1)) begin
        write_word_nxt = '0;
        write_slot_nxt = next_slot(write_slot_r);
        tiles_held_nxt = tiles_held_r + HELD_W'(1);
      end else begin
        write_word_nxt = write_word_r + WWORD_W'(1);
      end
    end
    if (do_lookup) begin
      if (done_hit) begin
        lookups_done_nxt = '0;
        read_slot_nxt    = next_slot(read_slot_r);
        tiles_held_nxt   = tiles_held_r - HELD_W'(1);
      end else begin
        lookups_done_nxt = lookups_done_r + COUNT_W'(1);
      end
    end
  end

  // store requests
  always_comb begin
    wr.en     = do_write;
    wr.addr   = {write_slot_r, write_word_r[WWORD_W-1:LANE_W]};
    wr.lane   = write_word_r[LANE_W-1:0];
    wr.data   = in_load_word;
    rd.en     = do_lookup && in_tile;
    rd.addr_a = {read_slot_r, row};
    rd.addr_b = {read_slot_r, row + ROW_IDX_W'(1)};
  end

  // result context for the select stage
  always_comb begin
    meta_nxt.valid     = accept && !do_write;
    meta_nxt.col       = col;
    meta_nxt.row_last  = (row == ROW_IDX_W'(TILE_ROWS - 1));
    meta_nxt.col_last  = (col == COL_W'(TILE_DIM - 1));
    meta_nxt.frac_x    = in_dx[OFS_W-1 -: PIX_W];
    meta_nxt.frac_y    = in_dy[OFS_W-1 -: PIX_W];
    meta_nxt.tile_done = do_lookup && done_hit;
    if (is_load) meta_nxt.status = ST_REFUSED;
    else if (ring_empty) meta_nxt.status = ST_NO_TILE;
    else if (!in_tile) meta_nxt.status = ST_OUTSIDE;
    else meta_nxt.status = ST_PIXELS;
  end

  // config register
  always_comb begin
    cfg_wr    = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_LOOKUPS_PER_TILE);
    limit_nxt = cfg_wr ? pwdata[LIMIT_W-1:0] : limit_r;
    if (paddr[PADDR_W-1] == REG_LOOKUPS_PER_TILE) prdata = PDATA_W'(limit_r);
    else prdata = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r   <= '0;
      write_word_r   <= '0;
      read_slot_r    <= '0;
      tiles_held_r   <= '0;
      lookups_done_r <= '0;
      limit_r        <= LIMIT_RESET;
      meta_r.valid   <= 1'b0;
    end else begin
      write_slot_r   <= write_slot_nxt;
      write_word_r   <= write_word_nxt;
      read_slot_r    <= read_slot_nxt;
      tiles_held_r   <= tiles_held_nxt;
      lookups_done_r <= lookups_done_nxt;
      limit_r        <= limit_nxt;
      meta_r         <= meta_nxt;
    end
  end

  // ring never holds more tiles than it has slots
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    tiles_held_r <= HELD_W'(NUM_TILES))
    else $error("tile count exceeds ring size");

  // an empty ring has its read and write slots together
  a_empty_slots: assert property (@(posedge clk) disable iff (!rst_n)
    (tiles_held_r == '0) |-> (write_slot_r == read_slot_r))
    else $error("slots apart while ring empty");

  // the lookup count restarts whenever no tile is held
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (tiles_held_r == '0) |-> (lookups_done_r == '0))
    else $error("lookup count left over with no tile");

  // a finishing lookup frees exactly one tile
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (do_lookup && done_hit) |=> (tiles_held_r == $past(tiles_held_r) - HELD_W'(1)))
    else $error("tile release miscounted");

endmodule
`default_nettype wire

// ===== sv/tbbf_select.sv =====
// neighbour pixel selection and result register
`default_nettype none
module tbbf_select (
  input  wire                          clk,
  input  wire                          rst_n,
  input  tbbf_pkg::meta_t              meta_r,
  input  wire  [tbbf_pkg::ROW_W-1:0]   row_a,
  input  wire  [tbbf_pkg::ROW_W-1:0]   row_b,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [tbbf_pkg::PIX_W-1:0]   out_pixel_here,
  output logic [tbbf_pkg::PIX_W-1:0]   out_pixel_below,
  output logic [tbbf_pkg::PIX_W-1:0]   out_pixel_right,
  output logic [tbbf_pkg::PIX_W-1:0]   out_pixel_diag,
  output logic [tbbf_pkg::PIX_W-1:0]   out_frac_x,
  output logic [tbbf_pkg::PIX_W-1:0]   out_frac_y,
  output logic                         out_tile_done
);
  import tbbf_pkg::*;

  logic             valid_r;
  logic [1:0]       status_r;
  logic [PIX_W-1:0] here_r, below_r, right_r, diag_r, frac_x_r, frac_y_r;
  logic             done_r;
  logic [PIX_W-1:0] here_nxt, below_nxt, right_nxt, diag_nxt, frac_x_nxt, frac_y_nxt;
  logic [COL_W-1:0] col_next;
  logic             give;

  // neighbours from the addressed row and the row under it, edge fill outside
  always_comb begin
    give       = (meta_r.status == ST_PIXELS);
    col_next   = meta_r.col + COL_W'(1);
    here_nxt   = '0;
    below_nxt  = '0;
    right_nxt  = '0;
    diag_nxt   = '0;
    frac_x_nxt = '0;
    frac_y_nxt = '0;
    if (give) begin
      here_nxt   = row_pixel(row_a, meta_r.col);
      below_nxt  = meta_r.row_last ? EDGE_FILL : row_pixel(row_b, meta_r.col);
      right_nxt  = meta_r.col_last ? EDGE_FILL : row_pixel(row_a, col_next);
      diag_nxt   = (meta_r.row_last || meta_r.col_last) ? EDGE_FILL
                                                        : row_pixel(row_b, col_next);
      frac_x_nxt = meta_r.frac_x;
      frac_y_nxt = meta_r.frac_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= meta_r.valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    status_r <= meta_r.status;
    here_r   <= here_nxt;
    below_r  <= below_nxt;
    right_r  <= right_nxt;
    diag_r   <= diag_nxt;
    frac_x_r <= frac_x_nxt;
    frac_y_r <= frac_y_nxt;
    done_r   <= meta_r.tile_done;
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_pixel_here  = here_r;
  assign out_pixel_below = below_r;
  assign out_pixel_right = right_r;
  assign out_pixel_diag  = diag_r;
  assign out_frac_x      = frac_x_r;
  assign out_frac_y      = frac_y_r;
  assign out_tile_done   = done_r;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for the tile buffer with bilinear neighbour fetch: directed and random commands
`timescale 1ns / 100ps
module tb_top;
  import tbbf_pkg::*;

  localparam int RESULT_LATENCY = 2;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 200;

  // one fetch result as seen on the output ports
  typedef struct packed {
    status_t          status;
    logic [PIX_W-1:0] here;
    logic [PIX_W-1:0] below;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] diag;
    logic [PIX_W-1:0] frac_x;
    logic [PIX_W-1:0] frac_y;
    logic             done;
  } fetch_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_func = FUNC_LOAD;
  logic [WORD_W-1:0]   in_load_word = '0;
  logic [COORD_W-1:0]  in_x = '0;
  logic [COORD_W-1:0]  in_y = '0;
  logic [OFS_W-1:0]    in_dx = '0;
  logic [OFS_W-1:0]    in_dy = '0;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [PIX_W-1:0]    out_pixel_here;
  logic [PIX_W-1:0]    out_pixel_below;
  logic [PIX_W-1:0]    out_pixel_right;
  logic [PIX_W-1:0]    out_pixel_diag;
  logic [PIX_W-1:0]    out_frac_x;
  logic [PIX_W-1:0]    out_frac_y;
  logic                out_tile_done;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // mirror of the tile ring and its pointers
  logic [WORD_W-1:0]   tile_mirror [NUM_TILES*TILE_WORDS];
  logic [SLOT_W-1:0]   fill_slot = '0;
  logic [WWORD_W-1:0]  fill_word = '0;
  logic [SLOT_W-1:0]   fetch_slot = '0;
  logic [HELD_W-1:0]   tiles_ready = '0;
  logic [COUNT_W-1:0]  lookup_count = '0;
  logic [LIMIT_W-1:0]  lookup_limit = LIMIT_RESET;

  fetch_result_t       pending_fetch[$];
  int                  mismatches = 0;
  int                  cycle_count = 0;
  bit                  no_gaps = 1'b0;

  tile_buffer_bilinear_fetch DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_load_word(in_load_word), .in_x(in_x), .in_y(in_y),
    .in_dx(in_dx), .in_dy(in_dy),
    .out_valid(out_valid), .out_status(out_status),
    .out_pixel_here(out_pixel_here), .out_pixel_below(out_pixel_below),
    .out_pixel_right(out_pixel_right), .out_pixel_diag(out_pixel_diag),
    .out_frac_x(out_frac_x), .out_frac_y(out_frac_y), .out_tile_done(out_tile_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic string fmt_fetch(input fetch_result_t r);
    return $sformatf("status=%0d here=%h below=%h right=%h diag=%h fx=%h fy=%h done=%b",
                     r.status, r.here, r.below, r.right, r.diag, r.frac_x, r.frac_y, r.done);
  endfunction

  task automatic report_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endtask

  // pixel p of the tile currently being read
  function automatic logic [PIX_W-1:0] tile_px(input logic [7:0] p);
    logic [WORD_W-1:0] w;
    w = tile_mirror[int'(fetch_slot) * TILE_WORDS + int'(p[7:2])];
    return w[p[1:0]*PIX_W +: PIX_W];
  endfunction

  // advance the mirror by one accepted command and queue its result, if it gives one
  task automatic predict_fetch(input logic func, input logic [WORD_W-1:0] word,
                               input logic [7:0] x, input logic [7:0] y,
                               input logic [15:0] dx, input logic [15:0] dy);
    fetch_result_t r;
    logic [12:0]   p;
    logic [7:0]    p8;
    logic          row_last;
    logic          col_last;
    int            lim;
    r = '0;
    if (func == FUNC_LOAD) begin
      if (int'(tiles_ready) >= NUM_TILES) begin
        r.status = ST_REFUSED;
        pending_fetch.push_back(r);
      end else begin
        tile_mirror[int'(fill_slot) * TILE_WORDS + int'(fill_word)] = word;
        if (int'(fill_word) == TILE_WORDS - 1) begin
          fill_word = '0;
          fill_slot = (int'(fill_slot) == NUM_TILES - 1) ? '0 : fill_slot + SLOT_W'(1);
          tiles_ready = tiles_ready + HELD_W'(1);
        end else begin
          fill_word = fill_word + WWORD_W'(1);
        end
      end
    end else if (tiles_ready == '0) begin
      r.status = ST_NO_TILE;
      pending_fetch.push_back(r);
    end else begin
      p = {5'd0, x} + {1'b0, y, 4'd0};
      if (p < 13'd256) begin
        p8       = p[7:0];
        row_last = (p8[7:4] == 4'hF);
        col_last = (p8[3:0] == 4'hF);
        r.status = ST_PIXELS;
        r.here   = tile_px(p8);
        r.below  = row_last ? EDGE_FILL : tile_px(p8 + 8'd16);
        r.right  = col_last ? EDGE_FILL : tile_px(p8 + 8'd1);
        r.diag   = (row_last || col_last) ? EDGE_FILL : tile_px(p8 + 8'd17);
        r.frac_x = dx[15:8];
        r.frac_y = dy[15:8];
      end else begin
        r.status = ST_OUTSIDE;
      end
      // out-of-range limits are clamped to 1..4096
      lim = int'(lookup_limit);
      if (lim == 0) lim = 1;
      if (lim > int'(LIMIT_MAX)) lim = int'(LIMIT_MAX);
      if (int'(lookup_count) + 1 >= lim) begin
        lookup_count = '0;
        fetch_slot   = (int'(fetch_slot) == NUM_TILES - 1) ? '0 : fetch_slot + SLOT_W'(1);
        tiles_ready  = tiles_ready - HELD_W'(1);
        r.done       = 1'b1;
      end else begin
        lookup_count = lookup_count + COUNT_W'(1);
      end
      pending_fetch.push_back(r);
    end
  endtask

  // compare every result strobe with the oldest expectation
  always @(posedge clk) begin : result_check
    fetch_result_t got;
    fetch_result_t want;
    if (rst_n && out_valid) begin
      got.status = status_t'(out_status);
      got.here   = out_pixel_here;
      got.below  = out_pixel_below;
      got.right  = out_pixel_right;
      got.diag   = out_pixel_diag;
      got.frac_x = out_frac_x;
      got.frac_y = out_frac_y;
      got.done   = out_tile_done;
      if (pending_fetch.size() == 0) begin
        report_error($sformatf("unexpected result %s", fmt_fetch(got)));
      end else begin
        want = pending_fetch.pop_front();
        if (got !== want)
          report_error($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                 fmt_fetch(want), fmt_fetch(got)));
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // one command transfer, preceded by a random gap
  task automatic send_cmd(input logic func, input logic [WORD_W-1:0] word,
                          input logic [7:0] x, input logic [7:0] y,
                          input logic [15:0] dx, input logic [15:0] dy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    in_func      <= func;
    in_load_word <= word;
    in_x         <= x;
    in_y         <= y;
    in_dx        <= dx;
    in_dy        <= dy;
    do @(posedge clk); while (busy !== 1'b0);
    predict_fetch(func, word, x, y, dx, dy);
  endtask

  task automatic lookup_at(input logic [7:0] x, input logic [7:0] y,
                           input logic [15:0] dx, input logic [15:0] dy);
    send_cmd(FUNC_LOOKUP, $urandom, x, y, dx, dy);
  endtask

  task automatic fill_tile();
    repeat (TILE_WORDS)
      send_cmd(FUNC_LOAD, $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
               16'($urandom));
  endtask

  // stop issuing and let every outstanding result drain
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_fetch.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // apb read of lookups_per_tile, checked against the mirror
  task automatic check_limit_reg();
    logic [PDATA_W-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'(4 * REG_LOOKUPS_PER_TILE);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== PDATA_W'(lookup_limit))
      report_error($sformatf("lookups_per_tile read: expected %h actual %h",
                             PDATA_W'(lookup_limit), rd));
  endtask

  // apb write of lookups_per_tile while the block is idle
  task automatic write_limit(input logic [PDATA_W-1:0] value);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * REG_LOOKUPS_PER_TILE);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    lookup_limit = value[LIMIT_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_limit_reg();
  endtask

  // reset value of the register and lookups with an empty ring
  task automatic test_after_reset();
    check_limit_reg();
    lookup_at(8'd0, 8'd0, 16'h0000, 16'h0000);
    lookup_at(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
  endtask

  // full ring refuses loads; a limit of zero releases on every lookup
  task automatic test_ring_full();
    write_limit(32'd0);
    fill_tile();
    fill_tile();
    send_cmd(FUNC_LOAD, 32'hFFFF_FFFF, 8'd0, 8'd0, 16'd0, 16'd0);
    lookup_at(8'd15, 8'd15, 16'h00FF, 16'hFF00);
    send_cmd(FUNC_LOAD, 32'h0000_0000, 8'd0, 8'd0, 16'd0, 16'd0);
    lookup_at(8'd0, 8'd0, 16'hFFFF, 16'h0000);
    lookup_at(8'd1, 8'd1, 16'h1234, 16'h5678);
  endtask

  // corners, row and column edges, index wrap into the next row, outside
  task automatic test_tile_edges();
    write_limit(32'd8191);
    send_cmd(FUNC_LOAD, $urandom, 8'd0, 8'd0, 16'd0, 16'd0);
    repeat (TILE_WORDS - 2)
      send_cmd(FUNC_LOAD, $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
               16'($urandom));
    lookup_at(8'd0, 8'd0, 16'h0000, 16'hFFFF);
    lookup_at(8'd15, 8'd0, 16'h00FF, 16'h00FF);
    lookup_at(8'd0, 8'd15, 16'hFF00, 16'h8080);
    lookup_at(8'd15, 8'd15, 16'h7F7F, 16'h0100);
    lookup_at(8'd14, 8'd14, 16'hFFFF, 16'hFFFF);
    lookup_at(8'd16, 8'd0, 16'h8000, 16'h0080);
    lookup_at(8'd255, 8'd0, 16'h4321, 16'hABCD);
    lookup_at(8'd200, 8'd3, 16'h0000, 16'h0000);
    lookup_at(8'd0, 8'd16, 16'hFFFF, 16'hFFFF);
    lookup_at(8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
  endtask

  // lowering the limit below the running count releases on the next lookup
  task automatic test_limit_change();
    write_limit(32'd4096);
    lookup_at(8'd3, 8'd7, 16'hA5A5, 16'h5A5A);
    lookup_at(8'd12, 8'd2, 16'h0101, 16'hFEFE);
    write_limit(32'd5);
    lookup_at(8'd9, 8'd9, 16'h1111, 16'h2222);
    lookup_at(8'd9, 8'd9, 16'h1111, 16'h2222);
    // upper data bits beyond the register are dropped
    write_limit(32'hFFFF_E003);
    fill_tile();
    repeat (3) lookup_at(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                         16'($urandom), 16'($urandom));
  endtask

  task automatic random_item();
    logic       func;
    logic [7:0] x;
    logic [7:0] y;
    int         r;
    int         load_pct;
    case (int'(tiles_ready))
      0:       load_pct = 85;
      1:       load_pct = 40;
      default: load_pct = 8;
    endcase
    func = ($urandom_range(0, 99) < load_pct) ? FUNC_LOAD : FUNC_LOOKUP;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      x = 8'($urandom_range(0, 15));
      y = 8'($urandom_range(0, 15));
    end else if (r < 90) begin
      y = 8'($urandom_range(0, 15));
      x = 8'($urandom_range(0, 255 - 16 * int'(y)));
    end else begin
      x = 8'($urandom);
      y = 8'($urandom);
    end
    send_cmd(func, $urandom, x, y, 16'($urandom), 16'($urandom));
  endtask

  // phases of random traffic, each under its own limit
  task automatic test_random_traffic();
    logic [PDATA_W-1:0] lim;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       lim = 0;
        1:       lim = 1;
        2, 3:    lim = $urandom_range(2, 8);
        4, 5, 6: lim = $urandom_range(9, 64);
        7:       lim = $urandom_range(65, 300);
        8:       lim = 4096;
        default: lim = 8191;
      endcase
      write_limit(lim);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) random_item();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_ring_full();
    test_tile_edges();
    test_limit_change();
    test_random_traffic();
    drain();
    repeat (RESULT_LATENCY + 5) @(posedge clk);
    if (mismatches == 0 && pending_fetch.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tbbf_pkg.sv
sv/tbbf_store.sv
sv/tbbf_ctrl.sv
sv/tbbf_select.sv
sv/tile_buffer_bilinear_fetch.sv
sim/tb_top.sv
